>>> hw/rtl/sbs_pkg.sv
`timescale 1ns / 1ps

package sbs_pkg;

    localparam int TIMER_BITS_DEF = 32;
    localparam int BASE_PERIOD    = 11;
    localparam int MS_PER_SEC     = 1000;

    localparam int MS_BITS     = 10;
    localparam int LED_BITS    = 8;
    localparam int LEN_BITS    = 16;
    localparam int DUR_BITS    = LEN_BITS + 1;
    localparam int DRIVE_BITS  = 8;
    localparam int PROD_BITS   = MS_BITS + LED_BITS;
    localparam int RECIP_SHIFT = PROD_BITS + MS_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT - MS_BITS + 1;

    // ceil(2^RECIP_SHIFT / 1000): exact floor division for any product below 2^PROD_BITS
    localparam logic [RECIP_BITS-1:0] LED_RECIP =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / MS_PER_SEC + 1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BURST = 2'd1,
        PH_REST  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        MODE_SINGLE     = 2'd0,
        MODE_REPEAT     = 2'd1,
        MODE_CONTINUOUS = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        LED_RED   = 2'd0,
        LED_GREEN = 2'd1,
        LED_BLUE  = 2'd2
    } led_t;

    typedef enum logic [1:0] {
        REG_FLAME_MODE   = 2'd0,
        REG_BURST_LENGTH = 2'd1,
        REG_REST_LENGTH  = 2'd2,
        REG_LED_PEAK     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [DRIVE_BITS-1:0] drive_level;
    } cmd_t;

    typedef struct packed {
        logic                solenoid_on;
        logic                ignite_pulse;
        logic [1:0]          led_channel;
        logic [LED_BITS-1:0] led_level;
        logic [1:0]          phase_now;
    } result_t;

    typedef struct packed {
        logic [1:0]          index;
        logic [LEN_BITS-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [1:0]          flame_mode;
        logic [LEN_BITS-1:0] burst_length_ms;
        logic [LEN_BITS-1:0] rest_length_ms;
        logic [LED_BITS-1:0] led_peak;
    } cfg_t;

    typedef struct packed {
        logic                 solenoid_on;
        logic                 ignite_pulse;
        logic [1:0]           led_channel;
        logic [1:0]           phase_now;
        logic [PROD_BITS-1:0] product;
        logic                 second_odd;
        logic [LED_BITS-1:0]  led_peak;
    } stage_t;

endpackage

>>> hw/rtl/sbs_chan_if.sv
`timescale 1ns / 1ps

interface sbs_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/solenoid_burst_sequencer.sv
`timescale 1ns / 1ps

// Burst sequencer for a gas solenoid. Each cmd transfer (tick, start, end)
// yields exactly one result transfer, in order. One item is taken every clock
// while the result path does not stall; a cmd is registered in the core stage
// and then in the output register before its result is valid. The sequencer state
// (ms counter, phase, deadlines) is updated in the cycle the cmd is taken,
// which bounds the clock by a TIMER_BITS-wide increment, saturating add and
// compare; the LED product is registered and divided by 1000 in the output
// stage. Configuration writes are taken every cycle and should only be issued
// with no items in flight.
module solenoid_burst_sequencer
    import sbs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sbs_chan_if.sink    cmd,
    sbs_chan_if.sink    cfg,
    sbs_chan_if.source  result
);

    cfg_t regs;

    sbs_chan_if #(.T(stage_t)) stage_ch ();

    sbs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    sbs_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .regs  (regs),
        .stage (stage_ch)
    );

    sbs_led_scale u_led_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage_ch),
        .result (result)
    );

endmodule

>>> hw/rtl/sbs_cfg_regs.sv
`timescale 1ns / 1ps

module sbs_cfg_regs
    import sbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sbs_chan_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.flame_mode      <= '0;
            regs_reg.burst_length_ms <= '0;
            regs_reg.rest_length_ms  <= '0;
            regs_reg.led_peak        <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.payload.index))
                REG_FLAME_MODE:   regs_reg.flame_mode      <= cfg.payload.data[1:0];
                REG_BURST_LENGTH: regs_reg.burst_length_ms <= cfg.payload.data;
                REG_REST_LENGTH:  regs_reg.rest_length_ms  <= cfg.payload.data;
                REG_LED_PEAK:     regs_reg.led_peak        <= cfg.payload.data[LED_BITS-1:0];
            endcase
        end
    end

endmodule

>>> hw/rtl/sbs_core.sv
`timescale 1ns / 1ps

module sbs_core
    import sbs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sbs_chan_if.sink    cmd,
    input  cfg_t        regs,
    sbs_chan_if.source  stage
);

    localparam int TW = TIMER_BITS;
    localparam logic [MS_BITS-1:0] MS_LAST = MS_BITS'(MS_PER_SEC - 1);
    localparam logic [DRIVE_BITS:0] BASE  = (DRIVE_BITS + 1)'(BASE_PERIOD);

    logic [TW-1:0]      now_reg, now_next;
    phase_t             phase_reg, phase_next;
    logic [TW-1:0]      mark_reg, mark_next;
    logic [TW-1:0]      deadline_reg, deadline_next;
    logic               next_drive_reg, next_drive_next;
    logic               valve_reg, valve_next;
    logic [MS_BITS-1:0] ms_reg, ms_next;
    logic               odd_reg, odd_next;
    logic               stage_valid_reg;
    stage_t             stage_reg;

    logic               accept;
    logic               ignite;
    logic [TW-1:0]      tick_now;
    logic [DRIVE_BITS:0] drive_ext;
    logic [DUR_BITS-1:0] closed_time;
    logic [DUR_BITS-1:0] open_time;
    led_t               chan;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [DUR_BITS-1:0] b);
        logic [TW:0] sum;
        sum = {1'b0, a} + (TW + 1)'(b);
        return sum[TW] ? '1 : sum[TW-1:0];
    endfunction

    assign cmd.ready     = !stage_valid_reg || stage.ready;
    assign accept        = cmd.valid && cmd.ready;
    assign stage.valid   = stage_valid_reg;
    assign stage.payload = stage_reg;

    assign tick_now    = now_reg + 1'b1;
    assign drive_ext   = {1'b0, cmd.payload.drive_level};
    assign closed_time = DUR_BITS'(BASE + drive_ext);
    assign open_time   = (drive_ext < BASE) ? DUR_BITS'(BASE - drive_ext) : '0;

    always_comb
    begin
        now_next        = now_reg;
        phase_next      = phase_reg;
        mark_next       = mark_reg;
        deadline_next   = deadline_reg;
        next_drive_next = next_drive_reg;
        valve_next      = valve_reg;
        ms_next         = ms_reg;
        odd_next        = odd_reg;
        ignite          = 1'b0;

        unique case (op_t'(cmd.payload.opcode))
            OP_TICK:
            begin
                now_next = tick_now;
                if (ms_reg == MS_LAST)
                begin
                    ms_next  = '0;
                    odd_next = ~odd_reg;
                end
                else
                begin
                    ms_next = ms_reg + 1'b1;
                end

                unique case (phase_reg)
                    PH_BURST:
                    begin
                        if (tick_now > deadline_reg)
                        begin
                            valve_next      = next_drive_reg;
                            next_drive_next = ~next_drive_reg;
                            deadline_next   = sat_add(tick_now,
                                next_drive_reg ? open_time : closed_time);
                        end
                        if (tick_now > sat_add(mark_reg, DUR_BITS'(regs.burst_length_ms)))
                        begin
                            unique case (mode_t'(regs.flame_mode))
                                MODE_SINGLE:
                                begin
                                    valve_next = 1'b0;
                                    phase_next = PH_IDLE;
                                end
                                MODE_REPEAT:
                                begin
                                    valve_next = 1'b0;
                                    phase_next = PH_REST;
                                    mark_next  = tick_now;
                                end
                                default: ;
                            endcase
                        end
                    end
                    PH_REST:
                    begin
                        if (tick_now > sat_add(mark_reg, DUR_BITS'(regs.rest_length_ms)))
                        begin
                            phase_next    = PH_BURST;
                            mark_next     = tick_now;
                            deadline_next = tick_now;
                            ignite        = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START:
            begin
                phase_next    = PH_BURST;
                mark_next     = now_reg;
                deadline_next = now_reg;
            end
            OP_END:
            begin
                valve_next = 1'b0;
                phase_next = PH_IDLE;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        unique case (mode_t'(regs.flame_mode))
            MODE_SINGLE:     chan = LED_BLUE;
            MODE_CONTINUOUS: chan = LED_GREEN;
            default:         chan = LED_RED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg         <= '0;
            phase_reg       <= PH_IDLE;
            mark_reg        <= '0;
            deadline_reg    <= '0;
            next_drive_reg  <= 1'b0;
            valve_reg       <= 1'b0;
            ms_reg          <= '0;
            odd_reg         <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                now_reg        <= now_next;
                phase_reg      <= phase_next;
                mark_reg       <= mark_next;
                deadline_reg   <= deadline_next;
                next_drive_reg <= next_drive_next;
                valve_reg      <= valve_next;
                ms_reg         <= ms_next;
                odd_reg        <= odd_next;
            end
            if (accept)
                stage_valid_reg <= 1'b1;
            else if (stage.ready)
                stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.solenoid_on  <= valve_next;
            stage_reg.ignite_pulse <= ignite;
            stage_reg.led_channel  <= chan;
            stage_reg.phase_now    <= phase_next;
            stage_reg.product      <= PROD_BITS'(ms_next) * PROD_BITS'(regs.led_peak);
            stage_reg.second_odd   <= odd_next;
            stage_reg.led_peak     <= regs.led_peak;
        end
    end

endmodule

>>> hw/rtl/sbs_led_scale.sv
`timescale 1ns / 1ps

module sbs_led_scale
    import sbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sbs_chan_if.sink    stage,
    sbs_chan_if.source  result
);

    localparam int FULL_BITS = PROD_BITS + RECIP_BITS;

    logic                 out_valid_reg;
    result_t              result_reg;
    logic                 load;
    logic [FULL_BITS-1:0] full;
    logic [LED_BITS-1:0]  scaled;
    logic [LED_BITS-1:0]  level;

    assign stage.ready    = !out_valid_reg || result.ready;
    assign load           = stage.valid && stage.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = result_reg;

    // product / 1000 by reciprocal multiply
    assign full   = FULL_BITS'(stage.payload.product) * FULL_BITS'(LED_RECIP);
    assign scaled = full[RECIP_SHIFT +: LED_BITS];
    assign level  = stage.payload.second_odd ? stage.payload.led_peak - scaled : scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.solenoid_on  <= stage.payload.solenoid_on;
            result_reg.ignite_pulse <= stage.payload.ignite_pulse;
            result_reg.led_channel  <= stage.payload.led_channel;
            result_reg.led_level    <= level;
            result_reg.phase_now    <= stage.payload.phase_now;
        end
    end

endmodule

>>> hw/rtl/sbs_checker.sv
`timescale 1ns / 1ps

module sbs_checker
    import sbs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                solenoid_on,
    input logic                ignite_pulse,
    input logic [1:0]          led_channel,
    input logic [LED_BITS-1:0] led_level,
    input logic [1:0]          phase_now
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({solenoid_on, ignite_pulse, led_channel, led_level, phase_now}))
        else $error("result changed while stalled");

    a_ignite_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ignite_pulse |-> phase_now == PH_BURST)
        else $error("igniter pulse outside a burst");

    a_valve_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_now != PH_BURST |-> !solenoid_on)
        else $error("valve open while idle or resting");

endmodule

bind solenoid_burst_sequencer sbs_checker u_sbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .solenoid_on  (result.payload.solenoid_on),
    .ignite_pulse (result.payload.ignite_pulse),
    .led_channel  (result.payload.led_channel),
    .led_level    (result.payload.led_level),
    .phase_now    (result.payload.phase_now)
);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import sbs_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int TAIL_CYCLES = 8;
    localparam int SEG_ITEMS   = 50;
    localparam int SEND_IDLE [4] = '{0, 77, 0, 8};
    localparam int RECV_STALL [4] = '{0, 0, 77, 8};
    localparam logic [1:0] SEG_MODES [8] = '{MODE_REPEAT, MODE_CONTINUOUS, MODE_SINGLE,
        MODE_UNUSED, MODE_REPEAT, MODE_REPEAT, MODE_SINGLE, MODE_REPEAT};

    typedef logic [TIMER_BITS_DEF-1:0] ms_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] mode;
        logic [LEN_BITS-1:0] burst;
        logic [LEN_BITS-1:0] rest;
        logic [LEN_BITS-1:0] peak;
    } reg_set_t;

    typedef struct {
        bit       is_cfg;
        cmd_t     cmd;
        bit       typed;
        result_t  want;
        reg_set_t regs;
    } stim_row_t;

    typedef struct {
        bit      typed;
        result_t want;
    } send_note_t;

    logic clk;
    logic rst_n;

    sbs_chan_if #(.T(cmd_t))    cmd_if ();
    sbs_chan_if #(.T(cfg_wr_t)) cfg_if ();
    sbs_chan_if #(.T(result_t)) res_if ();

    solenoid_burst_sequencer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .cfg    (cfg_if),
        .result (res_if)
    );

    // shadow registers
    logic [1:0]          mode_reg      = MODE_SINGLE;
    logic [LEN_BITS-1:0] burst_len_reg = '0;
    logic [LEN_BITS-1:0] rest_len_reg  = '0;
    logic [LED_BITS-1:0] peak_reg      = 8'hFF;

    // sequencer state
    ms_t                clock_ms   = '0;
    phase_t             seq_phase  = PH_IDLE;
    ms_t                mark_ms    = '0;
    ms_t                toggle_at  = '0;
    logic               open_next  = 1'b0;
    logic               valve      = 1'b0;
    logic [MS_BITS-1:0] ms_count   = '0;
    logic               odd_second = 1'b0;

    result_t    pending_results [$];
    send_note_t send_notes [$];
    stim_row_t  directed [$];

    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic ms_t clip_add(ms_t a, logic [LEN_BITS:0] b);
        logic [TIMER_BITS_DEF:0] s;
        s = {1'b0, a} + (TIMER_BITS_DEF + 1)'(b);
        return s[TIMER_BITS_DEF] ? '1 : s[TIMER_BITS_DEF-1:0];
    endfunction

    function automatic result_t advance_sequencer(cmd_t c);
        result_t             r;
        logic                ignite;
        logic [PROD_BITS-1:0] product;
        logic [LED_BITS-1:0] scaled;
        ignite = 1'b0;
        case (c.opcode)
            OP_TICK:
            begin
                clock_ms = clock_ms + 1'b1;
                if (ms_count == MS_PER_SEC - 1)
                begin
                    ms_count   = '0;
                    odd_second = ~odd_second;
                end
                else
                    ms_count = ms_count + 1'b1;
                if (seq_phase == PH_BURST)
                begin
                    if (clock_ms > toggle_at)
                    begin
                        valve = open_next;
                        if (!open_next)
                        begin
                            open_next = 1'b1;
                            toggle_at = clip_add(clock_ms,
                                (LEN_BITS + 1)'(BASE_PERIOD + c.drive_level));
                        end
                        else
                        begin
                            open_next = 1'b0;
                            toggle_at = clip_add(clock_ms,
                                (LEN_BITS + 1)'((c.drive_level < BASE_PERIOD) ?
                                                BASE_PERIOD - c.drive_level : 0));
                        end
                    end
                    if (clock_ms > clip_add(mark_ms, (LEN_BITS + 1)'(burst_len_reg)))
                    begin
                        if (mode_reg == MODE_SINGLE)
                        begin
                            valve     = 1'b0;
                            seq_phase = PH_IDLE;
                        end
                        else if (mode_reg == MODE_REPEAT)
                        begin
                            valve     = 1'b0;
                            seq_phase = PH_REST;
                            mark_ms   = clock_ms;
                        end
                    end
                end
                else if (seq_phase == PH_REST)
                begin
                    if (clock_ms > clip_add(mark_ms, (LEN_BITS + 1)'(rest_len_reg)))
                    begin
                        seq_phase = PH_BURST;
                        mark_ms   = clock_ms;
                        toggle_at = clock_ms;
                        ignite    = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                seq_phase = PH_BURST;
                mark_ms   = clock_ms;
                toggle_at = clock_ms;
            end
            OP_END:
            begin
                valve     = 1'b0;
                seq_phase = PH_IDLE;
            end
            default: ;
        endcase
        product = PROD_BITS'(ms_count) * PROD_BITS'(peak_reg);
        scaled  = LED_BITS'(product / MS_PER_SEC);
        r.solenoid_on  = valve;
        r.ignite_pulse = ignite;
        r.led_channel  = (mode_reg == MODE_SINGLE) ? LED_BLUE :
                         (mode_reg == MODE_CONTINUOUS) ? LED_GREEN : LED_RED;
        r.led_level    = odd_second ? peak_reg - scaled : scaled;
        r.phase_now    = seq_phase;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input result_t want, input result_t got);
        errors++;
        if (errors <= REPORT_MAX)
            $display("%0t %s: exp valve=%0d ign=%0d chan=%0d level=%0d phase=%0d",
                     $time, what, want.solenoid_on, want.ignite_pulse, want.led_channel,
                     want.led_level, want.phase_now,
                     " | got valve=%0d ign=%0d chan=%0d level=%0d phase=%0d",
                     got.solenoid_on, got.ignite_pulse, got.led_channel,
                     got.led_level, got.phase_now);
    endtask

    always @(posedge clk)
    begin
        result_t    got;
        result_t    want;
        result_t    calc;
        send_note_t note;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = res_if.payload;
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.solenoid_on !== want.solenoid_on ||
                        got.ignite_pulse !== want.ignite_pulse ||
                        got.led_channel !== want.led_channel ||
                        got.led_level !== want.led_level ||
                        got.phase_now !== want.phase_now)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.payload.index)
                    REG_FLAME_MODE:   mode_reg      = cfg_if.payload.data[1:0];
                    REG_BURST_LENGTH: burst_len_reg = cfg_if.payload.data;
                    REG_REST_LENGTH:  rest_len_reg  = cfg_if.payload.data;
                    REG_LED_PEAK:     peak_reg      = cfg_if.payload.data[LED_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd_if.valid && cmd_if.ready)
            begin
                calc = advance_sequencer(cmd_if.payload);
                note = send_notes.pop_front();
                pending_results.push_back(note.typed ? note.want : calc);
            end
        end
    end

    task automatic send_cmd(input cmd_t c, input bit typed, input result_t want);
        send_notes.push_back(send_note_t'{typed, want});
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_registers(input reg_set_t s);
        cfg_wr_t w [4];
        w[0] = cfg_wr_t'{REG_FLAME_MODE, s.mode};
        w[1] = cfg_wr_t'{REG_BURST_LENGTH, s.burst};
        w[2] = cfg_wr_t'{REG_REST_LENGTH, s.rest};
        w[3] = cfg_wr_t'{REG_LED_PEAK, s.peak};
        for (int i = 0; i < 4; i++)
        begin
            cfg_if.valid   <= 1'b1;
            cfg_if.payload <= w[i];
            @(posedge clk);
            while (!cfg_if.ready)
                @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic stim_row_t item_row(logic [1:0] op, logic [DRIVE_BITS-1:0] drv);
        stim_row_t row;
        row = '{default: '0};
        row.cmd = cmd_t'{op, drv};
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [1:0] op, logic [DRIVE_BITS-1:0] drv,
                                            result_t want);
        stim_row_t row;
        row = item_row(op, drv);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [1:0] mode, logic [LEN_BITS-1:0] burst,
                                          logic [LEN_BITS-1:0] rest, logic [LED_BITS-1:0] peak);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.regs   = reg_set_t'{16'(mode), burst, rest, 16'(peak)};
        return row;
    endfunction

    initial
    begin
        int                    pick;
        logic [1:0]            op;
        logic [DRIVE_BITS-1:0] drv;
        reg_set_t              settings;

        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;

        // defaults after reset: single burst, zero lengths, full LED peak
        directed.push_back(typed_row(OP_UNUSED, 8'hFF,
                                     result_t'{1'b0, 1'b0, LED_BLUE, 8'd0, PH_IDLE}));
        directed.push_back(typed_row(OP_TICK, 8'hFF,
                                     result_t'{1'b0, 1'b0, LED_BLUE, 8'd0, PH_IDLE}));
        directed.push_back(typed_row(OP_START, 8'h00,
                                     result_t'{1'b0, 1'b0, LED_BLUE, 8'd0, PH_BURST}));
        directed.push_back(typed_row(OP_TICK, 8'h00,
                                     result_t'{1'b0, 1'b0, LED_BLUE, 8'd0, PH_IDLE}));
        directed.push_back(typed_row(OP_END, 8'h00,
                                     result_t'{1'b0, 1'b0, LED_BLUE, 8'd0, PH_IDLE}));
        // repeat with zero lengths: rest, then restart with igniter
        directed.push_back(cfg_row(MODE_REPEAT, 16'h0000, 16'h0000, 8'h00));
        directed.push_back(item_row(OP_START, 8'h00));
        directed.push_back(typed_row(OP_TICK, 8'h00,
                                     result_t'{1'b0, 1'b0, LED_RED, 8'd0, PH_REST}));
        directed.push_back(typed_row(OP_TICK, 8'h00,
                                     result_t'{1'b0, 1'b1, LED_RED, 8'd0, PH_BURST}));
        // continuous: valve opens, zero open time closes it on the next tick
        directed.push_back(cfg_row(MODE_CONTINUOUS, 16'hFFFF, 16'hFFFF, 8'hFF));
        directed.push_back(item_row(OP_START, 8'h00));
        repeat (12)
            directed.push_back(item_row(OP_TICK, 8'h00));
        directed.push_back(item_row(OP_TICK, 8'hFF));
        directed.push_back(item_row(OP_TICK, 8'h00));
        // unused mode holds at burst end, lit red
        directed.push_back(cfg_row(MODE_UNUSED, 16'h0000, 16'h0000, 8'h80));
        directed.push_back(item_row(OP_START, 8'h00));
        directed.push_back(item_row(OP_TICK, 8'h00));
        directed.push_back(item_row(OP_END, 8'h00));

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                wait_idle();
                load_registers(directed[i].regs);
            end
            else
                send_cmd(directed[i].cmd, directed[i].typed, directed[i].want);
        end

        for (int seg = 0; seg < 8; seg++)
        begin
            wait_idle();
            send_idle_pct  = SEND_IDLE[seg / 2];
            recv_stall_pct = RECV_STALL[seg / 2];
            settings.mode  = (16'($urandom()) & 16'hFFFC) | 16'(SEG_MODES[seg]);
            settings.burst = (seg == 1) ? 16'hFFFF : (seg == 5) ? 16'h0000 :
                             16'($urandom_range(0, 60));
            settings.rest  = (seg == 3) ? 16'h0000 : (seg == 4) ? 16'hFFFF :
                             16'($urandom_range(0, 30));
            settings.peak  = {8'($urandom()), (seg == 0) ? 8'h00 : (seg == 4) ? 8'hFF :
                              8'($urandom_range(0, 255))};
            load_registers(settings);
            send_cmd(cmd_t'{OP_START, 8'h00}, 1'b0, '0);
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    op = OP_START;
                else if (pick < 8)
                    op = OP_END;
                else if (pick < 10)
                    op = OP_UNUSED;
                else
                    op = OP_TICK;
                drv = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 12)) :
                      8'($urandom_range(0, 255));
                if (n == SEG_ITEMS / 2 && seg[0])
                    wait_idle();
                send_cmd(cmd_t'{op, drv}, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        errors += pending_results.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
